// ===== hw/rtl/wfm_pkg.sv =====
// shared types, constants and the sine table of the windowed fft magnitude core
package wfm_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_POINTS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_KIND  = 8'd1;

    // window kinds
    localparam logic [1:0] WKIND_RECT     = 2'd0;
    localparam logic [1:0] WKIND_HAMMING  = 2'd1;
    localparam logic [1:0] WKIND_HANN     = 2'd2;
    localparam logic [1:0] WKIND_BLACKMAN = 2'd3;

    // window coefficients, q15
    localparam logic signed [15:0] HAMMING_BASE  = 16'sd17695;
    localparam logic signed [15:0] HAMMING_COEF  = 16'sd15073;
    localparam logic signed [15:0] HANN_BASE     = 16'sd16384;
    localparam logic signed [15:0] HANN_COEF     = 16'sd16384;
    localparam logic signed [15:0] BLACKMAN_BASE = 16'sd13763;
    localparam logic signed [15:0] BLACKMAN_COEF = 16'sd2621;
    localparam logic signed [19:0] WEIGHT_MAX    = 20'sd32767;

    // reset value of the size register and the smallest transform size
    localparam logic [15:0] FRAME_POINTS_RESET = 16'd128;
    localparam logic [15:0] MIN_POINTS = 16'd16;

    // quarter sine, 64 steps per quarter turn, q15
    localparam logic [15:0] QSINE [0:64] = '{
        16'd0,     16'd804,   16'd1608,  16'd2410,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
        16'd6393,  16'd7179,  16'd7962,  16'd8739,  16'd9512,  16'd10278, 16'd11039, 16'd11793,
        16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846, 16'd17530,
        16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787, 16'd21403, 16'd22005, 16'd22594,
        16'd23170, 16'd23731, 16'd24279, 16'd24811, 16'd25329, 16'd25832, 16'd26319, 16'd26790,
        16'd27245, 16'd27683, 16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956,
        16'd30273, 16'd30571, 16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971,
        16'd32137, 16'd32285, 16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728, 16'd32757,
        16'd32767
    };

    // one frame handed from the front to the back
    typedef struct packed {
        logic [3:0] log_n;
        logic [1:0] window;
        logic [7:0] mean;
    } wfm_job_t;

    // back end sequencer
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_W_ADDR,
        ST_W_DATA,
        ST_W_WEIGHT,
        ST_W_PROD,
        ST_W_WRITE,
        ST_B_RDA,
        ST_B_RDB,
        ST_B_LATB,
        ST_B_PROD,
        ST_B_SUM,
        ST_B_WRA,
        ST_B_WRB,
        ST_M_RD,
        ST_M_LAT,
        ST_M_SQ,
        ST_M_ADD,
        ST_M_ROOT,
        ST_M_OUT
    } wfm_state_t;

    // sine over a 256-step turn
    function automatic logic signed [15:0] sin_q15(input logic [7:0] step);
        logic [6:0] q;
        logic [15:0] m;
        if (step <= 8'd64) begin
            q = step[6:0];
        end else if (step <= 8'd128) begin
            q = 7'(8'd128 - step);
        end else if (step <= 8'd192) begin
            q = 7'(step - 8'd128);
        end else begin
            q = 7'(8'd0 - step);
        end
        m = QSINE[q];
        sin_q15 = (step > 8'd128) ? $signed(16'd0 - m) : $signed(m);
    endfunction

    // cosine is the sine a quarter turn on
    function automatic logic signed [15:0] cos_q15(input logic [7:0] step);
        cos_q15 = sin_q15(step + 8'd64);
    endfunction

endpackage

// ===== hw/rtl/windowed_fft_magnitude_core.sv =====
// windowed fft magnitude core: top level
//
// Samples arrive one per beat on the s_ stream (tdata[7:0] = sample). Once a
// frame of N samples is in (N from frame_points, clamped to 16..MAX_POINTS,
// a size that is not a power of two means MAX_POINTS), the frame mean is
// removed, the selected window applied, a radix-2 fft run in place and N/2
// magnitudes sent out on the m_ stream, bin 0 first, tlast on the final bin.
// Registers are written on the cfg_ channel: index 0 frame_points (discards
// a partial frame), index 1 window_kind. Write them only while idle.
// The back end works through the window pass one sample at a time, the
// butterflies ((N/2)*log2(N) of them) one at a time and the output bins
// one at a time, limited by the single port pair of the data memory and
// the bit-serial square root. The next frame is collected once the window
// pass has read the sample store.
// Reset (aresetn low, synchronous) restores frame_points 128, rectangular
// window and an empty frame. A stalled receiver holds the current bin in the
// output register and the back end waits; samples are refused once the
// next frame is full.
module windowed_fft_magnitude_core import wfm_pkg::*; #(
    parameter int MAX_POINTS = 128
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,    // [7:0] sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,    // [5:0] bin_index, [21:6] magnitude, zero pad
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);

    logic          samp_we;
    logic [AW-1:0] samp_waddr, samp_raddr;
    logic [7:0]    samp_wdata, samp_rdata;
    logic          push_valid, push_ready, pop_valid, pop_ready;
    wfm_job_t      push_data, pop_data;
    logic          samples_free;

    wfm_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .samp_we      (samp_we),
        .samp_waddr   (samp_waddr),
        .samp_wdata   (samp_wdata),
        .job_valid    (push_valid),
        .job_ready    (push_ready),
        .job_data     (push_data),
        .samples_free (samples_free)
    );

    // sample store
    wfm_ram #(.WIDTH(8), .DEPTH(MAX_POINTS)) u_sample_ram (
        .aclk  (aclk),
        .we    (samp_we),
        .waddr (samp_waddr),
        .wdata (samp_wdata),
        .raddr (samp_raddr),
        .rdata (samp_rdata)
    );

    wfm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    wfm_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (pop_valid),
        .job_ready    (pop_ready),
        .job_data     (pop_data),
        .samp_raddr   (samp_raddr),
        .samp_rdata   (samp_rdata),
        .samples_free (samples_free),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    // a completed frame always finds room in the job queue
    assert property (@(posedge aclk) disable iff (!aresetn) push_valid |-> push_ready)
        else $error("frame job dropped");

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // magnitude never exceeds the root of the largest power
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[21:6] <= 16'd46341))
        else $error("magnitude out of range");

    // the sample store is never released while no frame is being processed
    assert property (@(posedge aclk) disable iff (!aresetn) samples_free |-> !pop_ready)
        else $error("sample store released while idle");

endmodule

// ===== hw/rtl/wfm_ram.sv =====
// generic simple dual port ram with registered read
module wfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/wfm_front.sv =====
// sample collection, configuration registers and frame hand-off
module wfm_front import wfm_pkg::*; #(
    parameter int MAX_POINTS = 128,
    localparam int AW = $clog2(MAX_POINTS)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    output logic                   samp_we,
    output logic [AW-1:0]          samp_waddr,
    output logic [7:0]             samp_wdata,
    output logic                   job_valid,
    input  logic                   job_ready,
    output wfm_job_t               job_data,
    input  logic                   samples_free
);

    logic [15:0]   frame_points_reg, frame_points_next;
    logic [1:0]    window_kind_reg, window_kind_next;
    logic [AW-1:0] count_reg, count_next;
    logic [AW+7:0] sum_reg, sum_next;
    logic          blocked_reg, blocked_next;

    logic [15:0]   n_eff;
    logic [3:0]    log_n;
    logic [AW:0]   n_val;
    logic [AW+7:0] sum_new;
    logic          accept;
    logic          last;
    logic          cfg_wr;

    // effective transform size and its log
    always_comb begin
        n_eff = frame_points_reg;
        if (n_eff > 16'(MAX_POINTS)) begin
            n_eff = 16'(MAX_POINTS);
        end
        if (n_eff < MIN_POINTS) begin
            n_eff = MIN_POINTS;
        end
        if ((n_eff & (n_eff - 16'd1)) != 16'd0) begin
            n_eff = 16'(MAX_POINTS);
        end
        log_n = 4'd0;
        for (int b = 0; b < 16; b++) begin
            if (n_eff[b]) begin
                log_n = 4'(b);
            end
        end
    end

    assign n_val   = (AW+1)'(1) << log_n;
    assign last    = (count_reg == AW'(n_val - (AW+1)'(1)));
    assign sum_new = sum_reg + (AW+8)'(s_tdata);

    // input handshake, stalled while the back holds the sample store or the job queue is full
    assign s_tready  = !blocked_reg && job_ready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign samp_we    = accept;
    assign samp_waddr = count_reg;
    assign samp_wdata = s_tdata;

    assign job_valid       = accept && last;
    assign job_data.log_n  = log_n;
    assign job_data.window = window_kind_reg;
    assign job_data.mean   = 8'(sum_new >> log_n);

    // register updates
    always_comb begin
        frame_points_next = frame_points_reg;
        window_kind_next  = window_kind_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        blocked_next      = blocked_reg;
        if (samples_free) begin
            blocked_next = 1'b0;
        end
        if (cfg_wr) begin
            if (cfg_index == REG_FRAME_POINTS) begin
                frame_points_next = cfg_data;
                count_next        = '0;
                sum_next          = '0;
            end else if (cfg_index == REG_WINDOW_KIND) begin
                window_kind_next = cfg_data[1:0];
            end
        end else if (accept) begin
            if (last) begin
                count_next   = '0;
                sum_next     = '0;
                blocked_next = 1'b1;
            end else begin
                count_next = count_reg + AW'(1);
                sum_next   = sum_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_points_reg <= FRAME_POINTS_RESET;
            window_kind_reg  <= WKIND_RECT;
            count_reg        <= '0;
            sum_reg          <= '0;
            blocked_reg      <= 1'b0;
        end else begin
            frame_points_reg <= frame_points_next;
            window_kind_reg  <= window_kind_next;
            count_reg        <= count_next;
            sum_reg          <= sum_next;
            blocked_reg      <= blocked_next;
        end
    end

endmodule

// ===== hw/rtl/wfm_queue.sv =====
// two-entry frame job queue between front and back
module wfm_queue import wfm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  wfm_job_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output wfm_job_t pop_data
);

    wfm_job_t   entry_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/wfm_back.sv =====
// frame processing: window, radix-2 fft, magnitude and output register
module wfm_back import wfm_pkg::*; #(
    parameter int MAX_POINTS = 128,
    localparam int AW = $clog2(MAX_POINTS)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_ready,
    input  wfm_job_t      job_data,
    output logic [AW-1:0] samp_raddr,
    input  logic [7:0]    samp_rdata,
    output logic          samples_free,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,
    output logic          m_tlast
);

    wfm_state_t state_reg, state_next;
    wfm_job_t   job_reg;

    logic [AW-1:0] idx_reg;
    logic [3:0]    stage_reg;

    // window datapath
    logic signed [15:0] c1_reg, c2_reg;
    logic signed [8:0]  x_reg;
    logic signed [31:0] kp1_reg, kp2_reg;
    logic [14:0]        w_reg;
    logic signed [24:0] wp_reg;

    // butterfly datapath
    logic [AW-1:0]      a_addr_reg, b_addr_reg;
    logic signed [15:0] wr_reg, wi_reg;
    logic signed [15:0] are_reg, aim_reg, bre_reg, bim_reg;
    logic signed [31:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [15:0] tr_reg, ti_reg;

    // magnitude datapath
    logic [31:0] sq1_reg, sq2_reg;
    logic [31:0] v_reg, root_reg, bit_reg;

    // output register
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic        m_tlast_reg;

    // data memory port
    logic          dram_we;
    logic [AW-1:0] dram_waddr, dram_raddr;
    logic [31:0]   dram_wdata, dram_rdata;

    logic [AW:0]   n_val;
    logic          last_sample, last_pair, last_stage, last_bin;
    logic [AW-1:0] span, kmask, a_addr, b_addr, brev, rev;
    logic [7:0]    tw_step, st1, st2;
    logic          out_free;

    logic signed [15:0] coef1, base_w;
    logic signed [19:0] wsum;
    logic signed [32:0] sum_r, sum_i;
    logic signed [15:0] x_out;
    logic [16:0]        abs_re, abs_im;
    logic [33:0]        sq_re, sq_im;
    logic [31:0]        trial;

    wfm_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_data_ram (
        .aclk  (aclk),
        .we    (dram_we),
        .waddr (dram_waddr),
        .wdata (dram_wdata),
        .raddr (dram_raddr),
        .rdata (dram_rdata)
    );

    // frame size and loop ends
    assign n_val       = (AW+1)'(1) << job_reg.log_n;
    assign last_sample = (idx_reg == AW'(n_val - (AW+1)'(1)));
    assign last_pair   = (idx_reg == AW'((n_val >> 1) - (AW+1)'(1)));
    assign last_bin    = last_pair;
    assign last_stage  = (stage_reg == job_reg.log_n - 4'd1);

    // butterfly addressing and twiddle step
    assign span    = AW'(1) << stage_reg;
    assign kmask   = span - AW'(1);
    assign a_addr  = AW'(((idx_reg >> stage_reg) << (stage_reg + 4'd1)) | (idx_reg & kmask));
    assign b_addr  = a_addr | span;
    assign tw_step = 8'(idx_reg & kmask) << (4'd7 - stage_reg);

    // bit-reversed write address of the window pass
    always_comb begin
        for (int b = 0; b < AW; b++) begin
            rev[b] = idx_reg[AW-1-b];
        end
    end
    assign brev = rev >> (4'(AW) - job_reg.log_n);

    // window cosine steps
    assign st1 = 8'({idx_reg, 8'b0} >> job_reg.log_n);
    assign st2 = 8'({idx_reg, 9'b0} >> job_reg.log_n);

    // window weight
    always_comb begin
        case (job_reg.window)
            WKIND_HAMMING: begin
                coef1  = HAMMING_COEF;
                base_w = HAMMING_BASE;
            end
            WKIND_HANN: begin
                coef1  = HANN_COEF;
                base_w = HANN_BASE;
            end
            WKIND_BLACKMAN: begin
                coef1  = HANN_COEF;
                base_w = BLACKMAN_BASE;
            end
            default: begin
                coef1  = HANN_COEF;
                base_w = HANN_BASE;
            end
        endcase
        wsum = 20'(base_w) - 20'(kp1_reg >>> 15);
        if (job_reg.window == WKIND_BLACKMAN) begin
            wsum = wsum + 20'(kp2_reg >>> 15);
        end
    end

    // windowed sample
    always_comb begin
        if (job_reg.window == WKIND_RECT) begin
            x_out = {{7{x_reg[8]}}, x_reg};
        end else begin
            x_out = 16'(wp_reg >>> 15);
        end
    end

    // butterfly product sums
    assign sum_r = $signed({p1_reg[31], p1_reg}) - $signed({p2_reg[31], p2_reg});
    assign sum_i = $signed({p3_reg[31], p3_reg}) + $signed({p4_reg[31], p4_reg});

    // magnitude helpers
    assign abs_re = are_reg[15] ? (17'd0 - {1'b1, are_reg}) : {1'b0, are_reg};
    assign abs_im = aim_reg[15] ? (17'd0 - {1'b1, aim_reg}) : {1'b0, aim_reg};
    assign sq_re  = abs_re * abs_re;
    assign sq_im  = abs_im * abs_im;
    assign trial  = root_reg + bit_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer: next state and memory controls
    always_comb begin
        state_next   = state_reg;
        job_ready    = 1'b0;
        samples_free = 1'b0;
        samp_raddr   = idx_reg;
        dram_raddr   = a_addr;
        dram_we      = 1'b0;
        dram_waddr   = a_addr_reg;
        dram_wdata   = {x_out, 16'd0};
        case (state_reg)
            ST_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    state_next = ST_W_ADDR;
                end
            end
            ST_W_ADDR:   state_next = ST_W_DATA;
            ST_W_DATA:   state_next = ST_W_WEIGHT;
            ST_W_WEIGHT: state_next = ST_W_PROD;
            ST_W_PROD:   state_next = ST_W_WRITE;
            ST_W_WRITE: begin
                dram_we    = 1'b1;
                dram_waddr = brev;
                dram_wdata = {x_out, 16'd0};
                if (last_sample) begin
                    samples_free = 1'b1;
                    state_next   = ST_B_RDA;
                end else begin
                    state_next = ST_W_ADDR;
                end
            end
            ST_B_RDA: begin
                dram_raddr = a_addr;
                state_next = ST_B_RDB;
            end
            ST_B_RDB: begin
                dram_raddr = b_addr_reg;
                state_next = ST_B_LATB;
            end
            ST_B_LATB: state_next = ST_B_PROD;
            ST_B_PROD: state_next = ST_B_SUM;
            ST_B_SUM:  state_next = ST_B_WRA;
            ST_B_WRA: begin
                dram_we    = 1'b1;
                dram_waddr = a_addr_reg;
                dram_wdata = {16'(are_reg + tr_reg), 16'(aim_reg + ti_reg)};
                state_next = ST_B_WRB;
            end
            ST_B_WRB: begin
                dram_we    = 1'b1;
                dram_waddr = b_addr_reg;
                dram_wdata = {16'(are_reg - tr_reg), 16'(aim_reg - ti_reg)};
                if (last_pair && last_stage) begin
                    state_next = ST_M_RD;
                end else begin
                    state_next = ST_B_RDA;
                end
            end
            ST_M_RD: begin
                dram_raddr = idx_reg;
                state_next = ST_M_LAT;
            end
            ST_M_LAT: state_next = ST_M_SQ;
            ST_M_SQ:  state_next = ST_M_ADD;
            ST_M_ADD: state_next = ST_M_ROOT;
            ST_M_ROOT: begin
                if (bit_reg[0]) begin
                    state_next = ST_M_OUT;
                end
            end
            ST_M_OUT: begin
                if (out_free) begin
                    state_next = last_bin ? ST_IDLE : ST_M_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers and loop counters
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                job_reg   <= job_data;
                idx_reg   <= '0;
                stage_reg <= 4'd0;
            end
            ST_W_ADDR: begin
                c1_reg <= cos_q15(st1);
                c2_reg <= cos_q15(st2);
            end
            ST_W_DATA: begin
                x_reg   <= $signed({1'b0, samp_rdata}) - $signed({1'b0, job_reg.mean});
                kp1_reg <= coef1 * c1_reg;
                kp2_reg <= BLACKMAN_COEF * c2_reg;
            end
            ST_W_WEIGHT: begin
                if (wsum < 20'sd0) begin
                    w_reg <= 15'd0;
                end else if (wsum > WEIGHT_MAX) begin
                    w_reg <= 15'(WEIGHT_MAX);
                end else begin
                    w_reg <= 15'(wsum);
                end
            end
            ST_W_PROD: begin
                wp_reg <= x_reg * $signed({1'b0, w_reg});
            end
            ST_W_WRITE: begin
                idx_reg <= last_sample ? '0 : idx_reg + AW'(1);
            end
            ST_B_RDA: begin
                a_addr_reg <= a_addr;
                b_addr_reg <= b_addr;
                wr_reg     <= cos_q15(tw_step);
                wi_reg     <= 16'sd0 - sin_q15(tw_step);
            end
            ST_B_RDB: begin
                are_reg <= $signed(dram_rdata[31:16]);
                aim_reg <= $signed(dram_rdata[15:0]);
            end
            ST_B_LATB: begin
                bre_reg <= $signed(dram_rdata[31:16]);
                bim_reg <= $signed(dram_rdata[15:0]);
            end
            ST_B_PROD: begin
                p1_reg <= bre_reg * wr_reg;
                p2_reg <= bim_reg * wi_reg;
                p3_reg <= bre_reg * wi_reg;
                p4_reg <= bim_reg * wr_reg;
            end
            ST_B_SUM: begin
                tr_reg <= 16'(sum_r >>> 15);
                ti_reg <= 16'(sum_i >>> 15);
            end
            ST_B_WRB: begin
                if (last_pair) begin
                    idx_reg   <= '0;
                    stage_reg <= stage_reg + 4'd1;
                end else begin
                    idx_reg <= idx_reg + AW'(1);
                end
            end
            ST_M_LAT: begin
                are_reg <= $signed(dram_rdata[31:16]);
                aim_reg <= $signed(dram_rdata[15:0]);
            end
            ST_M_SQ: begin
                sq1_reg <= sq_re[31:0];
                sq2_reg <= sq_im[31:0];
            end
            ST_M_ADD: begin
                v_reg    <= sq1_reg + sq2_reg;
                root_reg <= 32'd0;
                bit_reg  <= 32'h4000_0000;
            end
            ST_M_ROOT: begin
                // one result bit per cycle
                if (v_reg >= trial) begin
                    v_reg    <= v_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            ST_M_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= {2'b00, root_reg[15:0], 6'(idx_reg)};
                    m_tlast_reg <= last_bin;
                    idx_reg     <= idx_reg + AW'(1);
                end
            end
            default: begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_M_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
